@@ hw/rtl/srs_pkg.sv @@
// Shared types and constants for the shard range splitter.
// No dependencies; every module of the block imports this package.
package srs_pkg;

   localparam int MAX_SHARDS  = 16;
   localparam int INDEX_WIDTH = 32;
   localparam int SLOT_WIDTH  = $clog2(MAX_SHARDS);
   localparam int COUNT_WIDTH = 5;
   localparam int DIV_STEPS   = INDEX_WIDTH;
   localparam int STEP_WIDTH  = $clog2(DIV_STEPS);

   localparam logic ACTION_WRITE = 1'b0;
   localparam logic ACTION_QUERY = 1'b1;

   localparam logic CSR_INTERLEAVED_MODE = 1'b0;
   localparam logic CSR_SHARD_COUNT      = 1'b1;

   typedef struct packed {
      logic                   action;
      logic [SLOT_WIDTH-1:0]  entry_slot;
      logic [INDEX_WIDTH-1:0] entry_total;
      logic [INDEX_WIDTH-1:0] start_index;
      logic [INDEX_WIDTH-1:0] query_count;
   } req_type;

   typedef struct packed {
      logic [SLOT_WIDTH-1:0]  shard_index;
      logic [INDEX_WIDTH-1:0] local_start;
      logic [INDEX_WIDTH-1:0] piece_length;
      logic [INDEX_WIDTH-1:0] out_offset;
      logic [COUNT_WIDTH-1:0] out_stride;
      logic                   last_piece;
      logic                   range_error;
   } rsp_type;

   typedef enum logic [1:0] {
      JOB_WRITE,
      JOB_CONCAT,
      JOB_INTERLEAVED
   } job_kind_type;

   typedef struct packed {
      job_kind_type           kind;
      logic [SLOT_WIDTH-1:0]  slot;
      logic [INDEX_WIDTH-1:0] total;
      logic [INDEX_WIDTH-1:0] start;
      logic [INDEX_WIDTH-1:0] count;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_IL_EMIT,
      ST_SEARCH,
      ST_CC_PREP,
      ST_CC_EMIT,
      ST_CC_FLUSH,
      ST_ERR
   } back_state_type;

endpackage

@@ hw/rtl/srs_front.sv @@
// Front end: accepts request transfers, classifies them, queues jobs.
// Depends on srs_pkg.
module srs_front
   import srs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   input  logic    interleaved,
   output logic    job_valid,
   output job_type job,
   input  logic    job_pop
);

   job_type     queue_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  fill_ff, fill_in;
   logic        accept;
   logic        push;
   job_type     new_job;

   assign req_stall = (fill_ff == 2'd2);
   assign accept    = req_valid && !req_stall;

   // Drop zero-count queries here: they produce nothing.
   always_comb begin
      new_job.slot  = req_data.entry_slot;
      new_job.total = req_data.entry_total;
      new_job.start = req_data.start_index;
      new_job.count = req_data.query_count;
      if (req_data.action == ACTION_WRITE) begin
         new_job.kind = JOB_WRITE;
      end else if (interleaved) begin
         new_job.kind = JOB_INTERLEAVED;
      end else begin
         new_job.kind = JOB_CONCAT;
      end
      push = accept && ((req_data.action == ACTION_WRITE) || (req_data.query_count != '0));
   end

   assign job_valid = (fill_ff != 2'd0);
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = job_pop ? ~rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, job_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= new_job;
      end
   end

endmodule

@@ hw/rtl/srs_back.sv @@
// Back end: table of running totals, search and division sequencer, result register.
// Depends on srs_pkg.
module srs_back
   import srs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic [COUNT_WIDTH-1:0] shards,
   input  logic                   job_valid,
   input  job_type                job,
   output logic                   job_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data
);

   back_state_type state_ff, state_in;

   logic [INDEX_WIDTH-1:0] table_ff [MAX_SHARDS];

   logic [INDEX_WIDTH-1:0] start_ff, last_ff;
   logic [INDEX_WIDTH-1:0] prev_ff, base_fs_ff, base_ls_ff;
   logic [INDEX_WIDTH-1:0] fl_ff, ll1_ff, off_ff;
   logic [SLOT_WIDTH-1:0]  idx_ff, fs_ff, ls_ff;
   logic                   fs_found_ff;
   logic                   pend_valid_ff;
   rsp_type                pend_ff;

   logic [STEP_WIDTH-1:0]  step_ff;
   logic [INDEX_WIDTH-1:0] qa_ff, qb_ff;
   logic [COUNT_WIDTH-1:0] ra_ff, rb_ff;
   logic [COUNT_WIDTH-1:0] sid_ff;
   logic [INDEX_WIDTH-1:0] lsi_ff;
   logic [COUNT_WIDTH-1:0] pieces_ff;

   logic    out_valid_ff;
   rsp_type out_data_ff;
   logic    out_free;
   logic    out_load;
   rsp_type out_next;

   logic [INDEX_WIDTH:0]   sum_wide;
   logic                   ovf;
   logic [INDEX_WIDTH-1:0] cur, st, en, len;
   logic                   hit_ls, hit_fs, at_end, piece_nz, cc_stall, cc_adv;
   logic [COUNT_WIDTH:0]   ra_sh, rb_sh;
   logic                   ra_ge, rb_ge;
   logic [COUNT_WIDTH-1:0] sid_inc;
   logic                   il_last;

   assign out_free = !out_valid_ff || !rsp_stall;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign sum_wide = {1'b0, job.start} + {1'b0, job.count} - {{INDEX_WIDTH{1'b0}}, 1'b1};
   assign ovf      = sum_wide[INDEX_WIDTH];

   assign cur      = table_ff[idx_ff];
   assign hit_ls   = cur > last_ff;
   assign hit_fs   = !fs_found_ff && (cur > start_ff);
   assign at_end   = ({1'b0, idx_ff} == shards - 5'd1);
   assign st       = (idx_ff == fs_ff) ? fl_ff : '0;
   assign en       = (idx_ff == ls_ff) ? ll1_ff : cur - prev_ff;
   assign len      = en - st;
   assign piece_nz = (len != '0);
   assign cc_stall = piece_nz && pend_valid_ff && !out_free;
   assign cc_adv   = !cc_stall;

   assign ra_sh   = {ra_ff, qa_ff[INDEX_WIDTH-1]};
   assign rb_sh   = {rb_ff, qb_ff[INDEX_WIDTH-1]};
   assign ra_ge   = ra_sh >= {1'b0, shards};
   assign rb_ge   = rb_sh >= {1'b0, shards};
   assign sid_inc = sid_ff + 5'd1;
   assign il_last = ({1'b0, step_ff[COUNT_WIDTH-2:0]} + 5'd1 == pieces_ff);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               case (job.kind)
                  JOB_CONCAT:      state_in = ovf ? ST_ERR : ST_SEARCH;
                  JOB_INTERLEAVED: state_in = ST_DIV;
                  default:         state_in = ST_IDLE;
               endcase
            end
         end
         ST_DIV: begin
            if (step_ff == STEP_WIDTH'(DIV_STEPS - 1)) state_in = ST_IL_EMIT;
         end
         ST_IL_EMIT: begin
            if (out_free && il_last) state_in = ST_IDLE;
         end
         ST_SEARCH: begin
            if (hit_ls) begin
               state_in = ST_CC_PREP;
            end else if (at_end) begin
               state_in = ST_ERR;
            end
         end
         ST_CC_PREP: state_in = ST_CC_EMIT;
         ST_CC_EMIT: begin
            if (cc_adv && (idx_ff == ls_ff)) state_in = ST_CC_FLUSH;
         end
         ST_CC_FLUSH: begin
            if (!pend_valid_ff || out_free) state_in = ST_IDLE;
         end
         ST_ERR: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs: queue pop and result register load.
   always_comb begin
      job_pop  = 1'b0;
      out_load = 1'b0;
      out_next = pend_ff;
      case (state_ff)
         ST_IDLE: job_pop = job_valid;
         ST_IL_EMIT: begin
            out_load              = out_free;
            out_next.shard_index  = sid_ff[SLOT_WIDTH-1:0];
            out_next.local_start  = lsi_ff;
            out_next.piece_length = qb_ff + ((step_ff[COUNT_WIDTH-2:0] < rb_ff[SLOT_WIDTH-1:0])
                                             ? {{(INDEX_WIDTH-1){1'b0}}, 1'b1} : '0);
            out_next.out_offset   = INDEX_WIDTH'(step_ff[COUNT_WIDTH-2:0]);
            out_next.out_stride   = shards;
            out_next.last_piece   = il_last;
            out_next.range_error  = 1'b0;
         end
         ST_CC_EMIT: begin
            out_load            = piece_nz && pend_valid_ff && out_free;
            out_next.last_piece = 1'b0;
         end
         ST_CC_FLUSH: begin
            out_load            = pend_valid_ff && out_free;
            out_next.last_piece = 1'b1;
         end
         ST_ERR: begin
            out_load              = out_free;
            out_next.shard_index  = '0;
            out_next.local_start  = '0;
            out_next.piece_length = '0;
            out_next.out_offset   = '0;
            out_next.out_stride   = COUNT_WIDTH'(1);
            out_next.last_piece   = 1'b1;
            out_next.range_error  = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         out_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
         if (state_ff == ST_CC_PREP) begin
            pend_valid_ff <= 1'b0;
         end else if ((state_ff == ST_CC_EMIT) && cc_adv && piece_nz) begin
            pend_valid_ff <= 1'b1;
         end else if ((state_ff == ST_CC_FLUSH) && out_free) begin
            pend_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath: no reset needed.
   always_ff @(posedge clock) begin
      if (out_load) out_data_ff <= out_next;
      case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               if (job.kind == JOB_WRITE) table_ff[job.slot] <= job.total;
               start_ff    <= job.start;
               last_ff     <= sum_wide[INDEX_WIDTH-1:0];
               idx_ff      <= '0;
               prev_ff     <= '0;
               fs_found_ff <= 1'b0;
               step_ff     <= '0;
               qa_ff       <= job.start;
               qb_ff       <= job.count;
               ra_ff       <= '0;
               rb_ff       <= '0;
               pieces_ff   <= (job.count < INDEX_WIDTH'(shards))
                              ? job.count[COUNT_WIDTH-1:0] : shards;
            end
         end
         ST_DIV: begin
            // One restoring step on both the start index and the count.
            qa_ff   <= {qa_ff[INDEX_WIDTH-2:0], ra_ge};
            qb_ff   <= {qb_ff[INDEX_WIDTH-2:0], rb_ge};
            ra_ff   <= ra_ge ? COUNT_WIDTH'(ra_sh - {1'b0, shards}) : ra_sh[COUNT_WIDTH-1:0];
            rb_ff   <= rb_ge ? COUNT_WIDTH'(rb_sh - {1'b0, shards}) : rb_sh[COUNT_WIDTH-1:0];
            if (step_ff == STEP_WIDTH'(DIV_STEPS - 1)) begin
               // First piece: shard start mod n, local index start / n.
               sid_ff  <= ra_ge ? COUNT_WIDTH'(ra_sh - {1'b0, shards}) : ra_sh[COUNT_WIDTH-1:0];
               lsi_ff  <= {qa_ff[INDEX_WIDTH-2:0], ra_ge};
               step_ff <= '0;
            end else begin
               step_ff <= step_ff + STEP_WIDTH'(1);
            end
         end
         ST_IL_EMIT: begin
            if (out_free) begin
               step_ff <= step_ff + STEP_WIDTH'(1);
               if (sid_inc >= shards) begin
                  sid_ff <= sid_inc - shards;
                  lsi_ff <= lsi_ff + INDEX_WIDTH'(1);
               end else begin
                  sid_ff <= sid_inc;
               end
            end
         end
         ST_SEARCH: begin
            if (hit_fs) begin
               fs_ff       <= idx_ff;
               base_fs_ff  <= prev_ff;
               fs_found_ff <= 1'b1;
            end
            if (hit_ls) begin
               ls_ff      <= idx_ff;
               base_ls_ff <= prev_ff;
            end else begin
               idx_ff  <= idx_ff + SLOT_WIDTH'(1);
               prev_ff <= cur;
            end
         end
         ST_CC_PREP: begin
            fl_ff   <= start_ff - base_fs_ff;
            ll1_ff  <= last_ff - base_ls_ff + INDEX_WIDTH'(1);
            idx_ff  <= fs_ff;
            prev_ff <= base_fs_ff;
            off_ff  <= '0;
         end
         ST_CC_EMIT: begin
            if (cc_adv) begin
               if (piece_nz) begin
                  pend_ff.shard_index  <= idx_ff;
                  pend_ff.local_start  <= st;
                  pend_ff.piece_length <= len;
                  pend_ff.out_offset   <= off_ff;
                  pend_ff.out_stride   <= COUNT_WIDTH'(1);
                  pend_ff.last_piece   <= 1'b0;
                  pend_ff.range_error  <= 1'b0;
               end
               off_ff  <= off_ff + len;
               prev_ff <= cur;
               idx_ff  <= idx_ff + SLOT_WIDTH'(1);
            end
         end
         default: ;
      endcase
   end

endmodule

@@ hw/rtl/shard_range_splitter_unit.sv @@
// Top level of the shard range splitter: configuration registers, front, back.
// Depends on srs_pkg, srs_front and srs_back.
//
//   channel  | ports                              | direction
//   ---------+------------------------------------+----------
//   request  | req_valid, req_stall, req_data     | in
//   result   | rsp_valid, rsp_stall, rsp_data     | out
//   control  | csr_write_enable, csr_index, csr_wdata | in
//
// A table write is done by the idle back end. A concatenated query searches the
// table entries in turn, runs a setup step, emits a piece per shard spanned and
// flushes the last piece. An interleaved query runs a 32-step restoring division
// of start and count by n, then emits one piece a cycle unless rsp_stall holds.
// A two-entry job queue lets the front keep taking transfers while the back
// works; the result register holds under rsp_stall. Reset is synchronous and
// clears control state only; table entries are undefined until written.
module shard_range_splitter_unit
   import srs_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_write_enable,
   input  logic                   csr_index,
   input  logic [COUNT_WIDTH-1:0] csr_wdata
);

   logic                   mode_ff;
   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] shards;
   logic                   job_valid;
   job_type                job;
   logic                   job_pop;

   // Holds config; the user writes it only while the block is idle (unchecked).
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= 1'b0;
         count_ff <= COUNT_WIDTH'(1);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INTERLEAVED_MODE: mode_ff  <= csr_wdata[0];
            CSR_SHARD_COUNT:      count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the shard count: zero acts as one, above the table size saturates.
   always_comb begin
      if (count_ff == '0) begin
         shards = COUNT_WIDTH'(1);
      end else if (count_ff > COUNT_WIDTH'(MAX_SHARDS)) begin
         shards = COUNT_WIDTH'(MAX_SHARDS);
      end else begin
         shards = count_ff;
      end
   end

   srs_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .interleaved (mode_ff),
      .job_valid   (job_valid),
      .job         (job),
      .job_pop     (job_pop)
   );

   srs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .shards    (shards),
      .job_valid (job_valid),
      .job       (job),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
